### design/tts_pkg.sv
package tts_pkg;

  // item kinds carried in tuser
  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_FETCH = 2'd3;

  // character codes
  localparam logic [7:0] CODE_CR     = 8'h0d;
  localparam logic [7:0] CODE_SPACE  = 8'h20;
  localparam logic [7:0] CODE_LAST   = 8'h7f;
  localparam logic [6:0] CELL_SPACE  = 7'h20;
  localparam logic [6:0] CELL_CURSOR = 7'h40;

  // configuration register indexes and reset values
  localparam logic       REG_BLINK_ON  = 1'b0;
  localparam logic       REG_BLINK_OFF = 1'b1;
  localparam logic [5:0] BLINK_ON_RESET  = 6'd20;
  localparam logic [5:0] BLINK_OFF_RESET = 6'd10;

  // port widths
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 24;

  typedef struct packed {
    logic load_item;   // latch the accepted item
    logic exec;        // run the item's action
    logic sweep_step;  // one cell of a scroll or fill sweep
    logic fill_all;    // sweep writes spaces everywhere
    logic out_load;    // capture the result
  } tts_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       scroll_needed;
    logic       sweep_last;
    logic       out_free;
  } tts_status_t;

endpackage

### design/tts_ctrl.sv
module tts_ctrl import tts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  tts_status_t status,
  output tts_cmd_t    cmd
);

  localparam logic [2:0] ST_INIT       = 3'd0;
  localparam logic [2:0] ST_INIT_DRAIN = 3'd1;
  localparam logic [2:0] ST_IDLE       = 3'd2;
  localparam logic [2:0] ST_EXEC       = 3'd3;
  localparam logic [2:0] ST_SWEEP      = 3'd4;
  localparam logic [2:0] ST_DRAIN      = 3'd5;
  localparam logic [2:0] ST_RESULT     = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      ST_INIT: begin
        cmd.sweep_step = 1'b1;
        cmd.fill_all   = 1'b1;
        if (status.sweep_last) state_next = ST_INIT_DRAIN;
      end
      ST_INIT_DRAIN: begin
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready      = 1'b1;
        cmd.load_item = s_tvalid;
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        if (status.kind == KIND_CLEAR || status.scroll_needed) begin
          state_next = ST_SWEEP;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        cmd.fill_all   = (status.kind == KIND_CLEAR);
        if (status.sweep_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        cmd.out_load = status.out_free;
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

### design/tts_datapath.sv
module tts_datapath import tts_pkg::*; #(
  parameter int COLUMNS = 40,
  parameter int ROWS    = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  tts_cmd_t            cmd,
  output tts_status_t         status,
  input  logic [1:0]          s_tuser,
  input  logic [S_DATA_W-1:0] s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [5:0]          cfg_data
);

  localparam int CELLS     = ROWS * COLUMNS;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int LAST_BASE = (ROWS - 1) * COLUMNS;

  // latched item
  logic [1:0] item_kind;
  logic [7:0] item_code;
  logic [4:0] item_row;
  logic [5:0] item_col;

  // cursor, blink, config
  logic [ROW_W-1:0] cur_row;
  logic [COL_W-1:0] cur_col;
  logic             cursor_lit;
  logic [5:0]       blink_count;
  logic [5:0]       lit_frames;
  logic [5:0]       dark_frames;

  // sweep
  logic [ADDR_W-1:0] sw;
  logic              pend;
  logic [ADDR_W-1:0] paddr;
  logic              pfill;
  logic              copying;

  // memory port
  logic [6:0]        mem [CELLS];
  logic              re;
  logic [ADDR_W-1:0] raddr;
  logic [6:0]        rdata;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [6:0]        wdata;

  // output register
  logic [6:0] o_char;
  logic [4:0] o_row;
  logic [5:0] o_col;
  logic       o_vis;

  logic              printable;
  logic              is_cr;
  logic              col_last;
  logic              row_last;
  logic              adv_row;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] fetch_addr;
  logic              in_range;
  logic              at_cursor;
  logic [6:0]        fetch_val;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_kind <= s_tuser;
      item_code <= s_tdata[7:0];
      item_row  <= s_tdata[12:8];
      item_col  <= s_tdata[18:13];
    end
  end

  assign printable = (item_code >= CODE_SPACE) && (item_code <= CODE_LAST);
  assign is_cr     = (item_code == CODE_CR);
  assign col_last  = (32'(cur_col) == 32'(COLUMNS - 1));
  assign row_last  = (32'(cur_row) == 32'(ROWS - 1));
  assign adv_row   = is_cr || (printable && col_last);
  assign cur_addr  = ADDR_W'(32'(cur_row) * 32'(COLUMNS) + 32'(cur_col));

  assign in_range   = (32'(item_row) < 32'(ROWS)) && (32'(item_col) < 32'(COLUMNS));
  assign fetch_addr = ADDR_W'(32'(item_row) * 32'(COLUMNS) + 32'(item_col));
  assign at_cursor  = (32'(item_row) == 32'(cur_row)) && (32'(item_col) == 32'(cur_col));

  always_comb begin
    if (!in_range) begin
      fetch_val = 7'd0;
    end else if (cursor_lit && at_cursor) begin
      fetch_val = CELL_CURSOR;
    end else begin
      fetch_val = rdata;
    end
  end

  // cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row <= '0;
      cur_col <= '0;
    end else if (cmd.exec) begin
      case (item_kind)
        KIND_PUT: begin
          if (is_cr || (printable && col_last)) begin
            cur_col <= '0;
          end else if (printable) begin
            cur_col <= cur_col + COL_W'(1);
          end
          if (adv_row && !row_last) cur_row <= cur_row + ROW_W'(1);
        end
        KIND_CLEAR: begin
          cur_row <= '0;
          cur_col <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // blink
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_lit  <= 1'b0;
      blink_count <= '0;
    end else if (cmd.exec && item_kind == KIND_TICK) begin
      if (blink_count != 6'd0) begin
        blink_count <= blink_count - 6'd1;
      end else begin
        cursor_lit  <= !cursor_lit;
        blink_count <= cursor_lit ? dark_frames : lit_frames;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lit_frames  <= BLINK_ON_RESET;
      dark_frames <= BLINK_OFF_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLINK_ON:  lit_frames  <= cfg_data;
        REG_BLINK_OFF: dark_frames <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sweep: read one row ahead, write in the following cycle
  assign copying = !cmd.fill_all && (32'(sw) < 32'(LAST_BASE));

  always_ff @(posedge clk) begin
    if (rst) begin
      sw   <= '0;
      pend <= 1'b0;
    end else begin
      pend <= cmd.sweep_step;
      if (cmd.sweep_step) begin
        sw <= status.sweep_last ? '0 : sw + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    paddr <= sw;
    pfill <= !copying;
  end

  always_comb begin
    re    = 1'b0;
    raddr = fetch_addr;
    if (cmd.sweep_step && copying) begin
      re    = 1'b1;
      raddr = ADDR_W'(32'(sw) + 32'(COLUMNS));
    end else if (cmd.exec && item_kind == KIND_FETCH && in_range) begin
      re = 1'b1;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = item_code[6:0];
    if (pend) begin
      we    = 1'b1;
      waddr = paddr;
      wdata = pfill ? CELL_SPACE : rdata;
    end else if (cmd.exec && item_kind == KIND_PUT && printable) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_char <= (item_kind == KIND_FETCH) ? fetch_val : 7'd0;
      o_row  <= 5'(cur_row);
      o_col  <= 6'(cur_col);
      o_vis  <= cursor_lit;
    end
  end

  assign m_tdata = {5'd0, o_vis, o_col, o_row, o_char};

  assign status.kind          = item_kind;
  assign status.scroll_needed = (item_kind == KIND_PUT) && adv_row && row_last;
  assign status.sweep_last    = (sw == ADDR_W'(CELLS - 1));
  assign status.out_free      = !m_tvalid || m_tready;

endmodule

### design/text_terminal_screen_writer_unit.sv
// Channel  Dir  Transfer when        Payload
// s_*      in   s_tvalid & s_tready  tuser: kind; tdata: char_code, cell_row, cell_col
// m_*      out  m_tvalid & m_tready  tdata: cell_char, cursor_row, cursor_col, cursor_visible
// cfg_*    in   cfg_we               cfg_index selects register, cfg_data 6 bits
//
// One item at a time: a put, tick or fetch goes through accept, execute and
// result. A scroll or a clear also sweeps the whole store through the single
// write port between execute and result.
// After reset a clearing pass fills the store with spaces, with s_tready low;
// config writes are taken during it.
// The result sits in an output register; a stalled m_tready holds only the
// next result, the next item is accepted meanwhile.
module text_terminal_screen_writer_unit import tts_pkg::*; #(
  parameter int COLUMNS = 40,
  parameter int ROWS    = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [1:0]          s_tuser,   // [1:0] kind
  input  logic [S_DATA_W-1:0] s_tdata,   // [7:0] char_code, [12:8] cell_row, [18:13] cell_col
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,   // [6:0] cell_char, [11:7] cursor_row,
                                         // [17:12] cursor_col, [18] cursor_visible
  input  logic                cfg_we,
  input  logic                cfg_index, // 0 cursor-on ticks, 1 cursor-off ticks
  input  logic [5:0]          cfg_data
);

  tts_cmd_t    cmd;
  tts_status_t status;

  // sequencer: reset fill, accept, execute, sweep, result
  tts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // cursor, blink timer, screen store and result register
  tts_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import tts_pkg::*;

  localparam int COLS  = 40;
  localparam int ROWS  = 24;
  localparam int CELLS = COLS * ROWS;

  // Slowest run: every item a full-store sweep plus the longest gap on each
  // side, up to about 540 items, taken several times over.
  localparam int CYCLE_LIMIT = 3_000_000;

  // One input item as the sender queues it. A fetch with aim set takes the
  // cursor position at the moment it is driven.
  typedef struct {
    logic [1:0] kind;
    logic [7:0] code;
    logic [4:0] row;
    logic [5:0] col;
    bit         aim;
  } scr_item_t;

  // One result transfer, field by field.
  typedef struct {
    logic [6:0] cell_char;
    logic [4:0] cursor_row;
    logic [5:0] cursor_col;
    logic       cursor_visible;
  } scr_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [1:0]          s_tuser = '0;     // [1:0] kind
  logic [S_DATA_W-1:0] s_tdata = '0;     // [7:0] char_code, [12:8] cell_row, [18:13] cell_col
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;          // [6:0] cell_char, [11:7] cursor_row,
                                         // [17:12] cursor_col, [18] cursor_visible
  logic                cfg_we = 1'b0;
  logic                cfg_index = REG_BLINK_ON;
  logic [5:0]          cfg_data = '0;

  text_terminal_screen_writer_unit #(
    .COLUMNS (COLS),
    .ROWS    (ROWS)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Screen predictor: own copy of the store, cursor, blink and blink settings.
  // ---------------------------------------------------------------------------
  logic [6:0] shadow_cells [0:CELLS-1];
  int         shadow_row;
  int         shadow_col;
  bit         shadow_blink;
  logic [5:0] shadow_count;
  logic [5:0] shadow_on_frames;
  logic [5:0] shadow_off_frames;

  task automatic shadow_reset();
    int i;
    for (i = 0; i < CELLS; i++) shadow_cells[i] = CELL_SPACE;
    shadow_row        = 0;
    shadow_col        = 0;
    shadow_blink      = 1'b0;
    shadow_count      = '0;
    shadow_on_frames  = BLINK_ON_RESET;
    shadow_off_frames = BLINK_OFF_RESET;
  endtask

  // Applies one accepted item to the shadow screen and returns its result.
  task automatic shadow_step(input scr_item_t it, output scr_result_t res);
    int         i;
    logic [6:0] shown;
    shown = '0;
    case (it.kind)
      KIND_PUT: begin
        if (it.code == CODE_CR) begin
          shadow_col = 0;
          shadow_row++;
        end else if (it.code >= CODE_SPACE && it.code <= CODE_LAST) begin
          shadow_cells[shadow_row * COLS + shadow_col] = it.code[6:0];
          shadow_col++;
          if (shadow_col >= COLS) begin
            shadow_col = 0;
            shadow_row++;
          end
        end
        // past the bottom: scroll up one row, blank the last row
        if (shadow_row >= ROWS) begin
          shadow_row = ROWS - 1;
          for (i = 0; i < (ROWS - 1) * COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
          for (i = (ROWS - 1) * COLS; i < CELLS; i++) shadow_cells[i] = CELL_SPACE;
        end
      end
      KIND_CLEAR: begin
        for (i = 0; i < CELLS; i++) shadow_cells[i] = CELL_SPACE;
        shadow_row = 0;
        shadow_col = 0;
      end
      KIND_TICK: begin
        if (shadow_count != 0) begin
          shadow_count--;
        end else begin
          shadow_blink = !shadow_blink;
          shadow_count = shadow_blink ? shadow_on_frames : shadow_off_frames;
        end
      end
      default: begin
        // fetch: out-of-range cells read as 0, the cursor shows while blinking
        if (int'(it.row) >= ROWS || int'(it.col) >= COLS) begin
          shown = '0;
        end else if (shadow_blink && int'(it.row) == shadow_row &&
                     int'(it.col) == shadow_col) begin
          shown = CELL_CURSOR;
        end else begin
          shown = shadow_cells[int'(it.row) * COLS + int'(it.col)];
        end
      end
    endcase
    res.cell_char      = shown;
    res.cursor_row     = 5'(shadow_row);
    res.cursor_col     = 6'(shadow_col);
    res.cursor_visible = shadow_blink;
  endtask

  // ---------------------------------------------------------------------------
  // Queues and counters shared by the sender, the monitor and the sequence.
  // ---------------------------------------------------------------------------
  scr_item_t   stim_q [$];    // items waiting for the sender
  scr_result_t screen_q [$];  // predicted results, oldest first
  int          sent_cnt = 0;  // items put on the slave side
  int          acc_cnt  = 0;  // items taken by the block
  int          errors   = 0;
  bit          no_idle  = 1'b0;
  int          src_gap  = 0;
  int          snk_gap  = 0;
  scr_item_t   next_item;
  scr_item_t   taken_item;
  scr_result_t want_r;
  scr_result_t got_r;

  // ---------------------------------------------------------------------------
  // Sender: drives at the falling edge, holds an item until its transfer.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && sent_cnt != acc_cnt) begin
      // still waiting for the transfer, keep everything stable
    end else if (src_gap != 0) begin
      src_gap--;
      s_tvalid <= 1'b0;
    end else if (stim_q.size() == 0) begin
      s_tvalid <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 11) == 0) begin
      // idle burst; src_gap counts the idle slots still to come
      src_gap = $urandom_range(0, 14);
      s_tvalid <= 1'b0;
    end else begin
      next_item = stim_q.pop_front();
      if (next_item.aim) begin
        // state is current here: every item sent so far has been taken
        next_item.row = 5'(shadow_row);
        next_item.col = 6'(shadow_col);
      end
      s_tvalid <= 1'b1;
      s_tuser  <= next_item.kind;
      s_tdata  <= {5'd0, next_item.col, next_item.row, next_item.code};
      sent_cnt++;
    end
  end

  // Receiver back-pressure: random stall bursts, none in the last phase.
  always @(negedge clk) begin
    if (snk_gap != 0) begin
      snk_gap--;
      m_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      snk_gap = $urandom_range(0, 14);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples at the rising edge. Results are checked before the item
  // taken at the same edge is predicted; the result register makes that order
  // safe.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_r.cell_char      = m_tdata[6:0];
      got_r.cursor_row     = m_tdata[11:7];
      got_r.cursor_col     = m_tdata[17:12];
      got_r.cursor_visible = m_tdata[18];
      if (screen_q.size() == 0) begin
        $display("%0t: unexpected result transfer, tdata %h", $time, m_tdata);
        errors++;
      end else begin
        want_r = screen_q.pop_front();
        if (got_r.cell_char !== want_r.cell_char) begin
          $display("%0t: cell_char expected %h got %h", $time,
                   want_r.cell_char, got_r.cell_char);
          errors++;
        end
        if (got_r.cursor_row !== want_r.cursor_row) begin
          $display("%0t: cursor_row expected %0d got %0d", $time,
                   want_r.cursor_row, got_r.cursor_row);
          errors++;
        end
        if (got_r.cursor_col !== want_r.cursor_col) begin
          $display("%0t: cursor_col expected %0d got %0d", $time,
                   want_r.cursor_col, got_r.cursor_col);
          errors++;
        end
        if (got_r.cursor_visible !== want_r.cursor_visible) begin
          $display("%0t: cursor_visible expected %b got %b", $time,
                   want_r.cursor_visible, got_r.cursor_visible);
          errors++;
        end
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      taken_item.kind = s_tuser;
      taken_item.code = s_tdata[7:0];
      taken_item.row  = s_tdata[12:8];
      taken_item.col  = s_tdata[18:13];
      taken_item.aim  = 1'b0;
      shadow_step(taken_item, want_r);
      screen_q.insert(screen_q.size(), want_r);
      acc_cnt++;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_item(logic [1:0] k, logic [7:0] c, logic [4:0] r,
                                     logic [5:0] cl, bit aim = 1'b0);
    scr_item_t it;
    it.kind = k;
    it.code = c;
    it.row  = r;
    it.col  = cl;
    it.aim  = aim;
    stim_q.insert(stim_q.size(), it);
  endfunction

  // Block idle: nothing queued, nothing in flight, every result seen.
  task automatic wait_drained();
    @(posedge clk);
    #1;
    while (stim_q.size() != 0 || sent_cnt != acc_cnt || screen_q.size() != 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  // Register write; the shadow copy follows at once since no item is in flight.
  task automatic write_reg(logic idx, logic [5:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_BLINK_ON) shadow_on_frames = val;
    else shadow_off_frames = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly text lines ended by carriage return, with fetches, ticks, the odd
  // clear, runs of returns that can push the cursor off the bottom, and noise.
  task automatic add_traffic(int n);
    int cnt;
    int pick;
    int len;
    int i;
    cnt = 0;
    while (cnt < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(38, 42) : $urandom_range(0, 10);
        for (i = 0; i < len; i++)
          queue_item(KIND_PUT, 8'($urandom_range(int'(CODE_SPACE), int'(CODE_LAST))),
                     5'($urandom), 6'($urandom));
        cnt += len;
        if ($urandom_range(0, 4) != 0) begin
          queue_item(KIND_PUT, CODE_CR, 5'($urandom), 6'($urandom));
          cnt++;
        end
      end else if (pick < 45) begin
        len = $urandom_range(20, 26);
        for (i = 0; i < len; i++) queue_item(KIND_PUT, CODE_CR, '0, '0);
        cnt += len;
      end else if (pick < 60) begin
        if ($urandom_range(0, 1) == 0)
          queue_item(KIND_FETCH, 8'($urandom), '0, '0, 1'b1);
        else
          queue_item(KIND_FETCH, 8'($urandom), 5'($urandom_range(0, ROWS - 1)),
                     6'($urandom_range(0, COLS - 1)));
        cnt++;
      end else if (pick < 78) begin
        len = $urandom_range(1, 4);
        for (i = 0; i < len; i++) queue_item(KIND_TICK, 8'($urandom), 5'($urandom), 6'($urandom));
        cnt += len;
      end else if (pick < 80) begin
        queue_item(KIND_CLEAR, 8'($urandom), 5'($urandom), 6'($urandom));
        cnt++;
      end else begin
        queue_item(2'($urandom), 8'($urandom), 5'($urandom), 6'($urandom));
        cnt++;
      end
    end
  endtask

  // Run limit
  int cycle_cnt = 0;
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    shadow_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: fast blink so the cursor shows up within a couple of ticks.
    // Writes land during the clearing pass, which the block accepts.
    write_reg(REG_BLINK_ON, 6'd1);
    write_reg(REG_BLINK_OFF, 6'd0);
    queue_item(KIND_FETCH, '0, 5'd0, 6'd0);      // blank cell, cursor hidden
    queue_item(KIND_TICK, '0, '0, '0);           // blink turns on
    queue_item(KIND_FETCH, '0, 5'd0, 6'd0);      // cursor glyph at home
    queue_item(KIND_PUT, 8'h41, '0, '0);
    queue_item(KIND_FETCH, '0, 5'd0, 6'd0);      // stored character
    queue_item(KIND_FETCH, '0, 5'd0, 6'd1);      // cursor moved on
    queue_item(KIND_PUT, CODE_LAST, '0, '0);     // last printable code
    queue_item(KIND_PUT, CODE_SPACE, '0, '0);    // first printable code
    queue_item(KIND_PUT, 8'h1f, '0, '0);         // control code, ignored
    queue_item(KIND_PUT, 8'h80, '0, '0);         // high codes, ignored
    queue_item(KIND_PUT, 8'hff, '0, '0);
    queue_item(KIND_PUT, 8'h00, '0, '0);
    queue_item(KIND_PUT, CODE_CR, '0, '0);       // next row, column 0
    queue_item(KIND_FETCH, '0, 5'd24, 6'd0);     // row past the bottom
    queue_item(KIND_FETCH, '0, 5'd31, 6'd63);    // both fields at their top
    queue_item(KIND_FETCH, '0, 5'd0, 6'd40);     // column past the edge
    queue_item(KIND_FETCH, '0, 5'd23, 6'd39);    // last real cell
    queue_item(KIND_TICK, '0, '0, '0);           // count down
    queue_item(KIND_TICK, '0, '0, '0);           // blink turns off
    queue_item(KIND_FETCH, '0, '0, '0, 1'b1);    // cursor cell, hidden
    queue_item(KIND_TICK, '0, '0, '0);
    queue_item(KIND_CLEAR, 8'hff, 5'd31, 6'd63);
    queue_item(KIND_FETCH, '0, 5'd0, 6'd0);      // cursor home, shown

    // Random phases; each starts only once the block has gone quiet, so the
    // sender also sits out until every pending result has arrived.
    wait_drained();
    write_reg(REG_BLINK_ON, 6'd3);
    write_reg(REG_BLINK_OFF, 6'd2);
    add_traffic(70);

    wait_drained();
    write_reg(REG_BLINK_ON, 6'd63);
    write_reg(REG_BLINK_OFF, 6'd0);
    add_traffic(60);

    wait_drained();
    write_reg(REG_BLINK_ON, 6'd0);
    write_reg(REG_BLINK_OFF, 6'd63);
    add_traffic(60);

    wait_drained();
    write_reg(REG_BLINK_ON, 6'd0);
    write_reg(REG_BLINK_OFF, 6'd0);
    add_traffic(60);

    // Last phase at full rate on both sides, blink back at reset values.
    wait_drained();
    write_reg(REG_BLINK_ON, BLINK_ON_RESET);
    write_reg(REG_BLINK_OFF, BLINK_OFF_RESET);
    no_idle = 1'b1;
    add_traffic(50);

    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### text_terminal_screen_writer_unit.f
design/tts_pkg.sv
design/tts_ctrl.sv
design/tts_datapath.sv
design/text_terminal_screen_writer_unit.sv
bench/tb_top.sv
